// ----- rtl/multi_task_liveness_watchdog_core_defines.svh -----
// assertion macros used by the checker file
`ifndef MULTI_TASK_LIVENESS_WATCHDOG_CORE_DEFINES_SVH
`define MULTI_TASK_LIVENESS_WATCHDOG_CORE_DEFINES_SVH

// antecedent in this cycle implies consequent in this cycle
`define MTLW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define MTLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtlw_pkg.sv -----
`default_nettype none

package mtlw_pkg;

  localparam int TASKS_DEFAULT = 4;
  localparam int TASK_IDX_W    = 4;
  localparam int TIME_W        = 32;
  localparam int CMD_W         = 2;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd5000;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEAT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // register index of max_age, taken from the word address bit
  localparam logic REG_MAX_AGE = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [TASK_IDX_W-1:0] task_index;
    logic [TIME_W-1:0]     now;
  } req_t;

  typedef struct packed {
    logic                  all_alive;
    logic [TASK_IDX_W-1:0] stalest_task;
    logic [TIME_W-1:0]     stalest_age;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic stamp_init;
    logic stamp_beat;
    logic query_start;
    logic walk_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/mtlw_datapath.sv -----
`default_nettype none

module mtlw_datapath
  import mtlw_pkg::*;
#(
  parameter int TASKS = TASKS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire req_t              req,
  input  wire logic [TIME_W-1:0] max_age,
  input  wire dp_cmd_t           dp_cmd,
  output dp_status_t             dp_status,
  output rsp_t                   rsp
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  logic [TIME_W-1:0] stamps [TASKS];
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  idx;
  logic              alive;
  logic [IDX_W-1:0]  worst;
  logic [TIME_W-1:0] peak_age;
  logic [TIME_W-1:0] age;
  logic              beat_ok;

  // wrap-safe age of the task under the walk pointer
  assign age     = now_q - stamps[idx];
  assign beat_ok = {1'b0, req.task_index} < (TASK_IDX_W + 1)'(TASKS);

  assign dp_status.walk_last = (idx == IDX_W'(TASKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASKS; i++) begin
        stamps[i] <= '0;
      end
    end else if (dp_cmd.stamp_init) begin
      for (int i = 0; i < TASKS; i++) begin
        stamps[i] <= req.now;
      end
    end else if (dp_cmd.stamp_beat && beat_ok) begin
      stamps[req.task_index[IDX_W-1:0]] <= req.now;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.query_start) begin
      now_q    <= req.now;
      idx      <= '0;
      alive    <= 1'b1;
      worst    <= '0;
      peak_age <= '0;
    end else if (dp_cmd.walk_step) begin
      if (age > max_age) begin
        alive <= 1'b0;
      end
      // later index wins a tie
      if (age >= peak_age) begin
        worst    <= idx;
        peak_age <= age;
      end
      if (!dp_status.walk_last) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.out_load) begin
      rsp.all_alive    <= alive;
      rsp.stalest_task <= TASK_IDX_W'(worst);
      rsp.stalest_age  <= peak_age;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mtlw_ctrl.sv -----
`default_nettype none

module mtlw_ctrl
  import mtlw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic [CMD_W-1:0] req_cmd,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  input  wire dp_status_t       dp_status,
  output dp_cmd_t               dp_cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_cmd == CMD_QUERY) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (dp_status.walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    accept    = 1'b0;
    dp_cmd    = '0;
    unique case (state)
      ST_IDLE: begin
        req_stall          = 1'b0;
        accept             = req_valid;
        dp_cmd.stamp_init  = accept && (req_cmd == CMD_INIT);
        dp_cmd.stamp_beat  = accept && (req_cmd == CMD_BEAT);
        dp_cmd.query_start = accept && (req_cmd == CMD_QUERY);
      end
      ST_WALK: begin
        dp_cmd.walk_step = 1'b1;
      end
      ST_DONE: begin
        dp_cmd.out_load = out_free;
      end
      default: begin
        dp_cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (dp_cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_task_liveness_watchdog_core.sv -----
// liveness watchdog over TASKS software tasks, one 32-bit heartbeat stamp each
// request channel (req_valid / req_stall / req) takes init, beat and query words
// init stamps every task with req.now, beat stamps one task (index >= TASKS ignored)
// init and beat give no response word and leave the request side open
// a query walks the stamps one task per cycle through a single subtract/compare,
// so it holds the request side through the walk and until its response is loaded
// response word (rsp_valid / rsp_stall / rsp) appears once the walk is done and
// the output register is free
// the response sits in an output register: while it is stalled, init and beat words
// are still taken, and a further query walks but waits in its last state until
// the earlier response leaves
// max_age is written over the apb port at byte address 0, reset value 5000
// reset (rst, synchronous) zeroes all stamps, empties the output, restores max_age
`default_nettype none

module multi_task_liveness_watchdog_core
  import mtlw_pkg::*;
#(
  parameter int TASKS = TASKS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire req_t                  req,
  // response channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output rsp_t                       rsp,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [TIME_W-1:0] max_age;
  logic              cfg_write;
  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;

  // apb: zero wait states, register picked by the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MAX_AGE_RESET;
    end else if (cfg_write && paddr[2] == REG_MAX_AGE) begin
      max_age <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_AGE: prdata = max_age;
      default:     prdata = '0;
    endcase
  end

  // sequencing of words and of the stamp walk
  mtlw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  // stamps, age compare and response register
  mtlw_datapath #(
    .TASKS (TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .max_age   (max_age),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/mtlw_checker.sv -----
`default_nettype none
`include "multi_task_liveness_watchdog_core_defines.svh"

module mtlw_checker
  import mtlw_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp,
  input wire logic pready
);

  logic rsp_held;
  logic query_take;
  logic stamp_take;

  assign rsp_held   = rsp_valid && rsp_stall;
  assign query_take = req_valid && !req_stall && req.cmd == CMD_QUERY;
  assign stamp_take = req_valid && !req_stall && (req.cmd == CMD_INIT || req.cmd == CMD_BEAT);

  `MTLW_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "rsp moved while stalled")
  `MTLW_ASSERT_NEXT(a_query_busy, query_take, req_stall, "query did not hold request side")
  `MTLW_ASSERT_NEXT(a_stamp_ready, stamp_take, !req_stall, "stamp word blocked request side")
  `MTLW_ASSERT_NOW(a_rsp_frees, $rose(rsp_valid), !req_stall && pready, "req busy at rsp load")

endmodule

bind multi_task_liveness_watchdog_core mtlw_checker u_mtlw_checker (.*);

`default_nettype wire
